// ----- design/swnm_pkg.sv -----
// ----------------------------------------------------------------------------
// swnm_pkg: shared types, constants and a function for the star-wildcard
// name matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package swnm_pkg;

   localparam int PAT_LIMIT       = 32;   // largest pattern the register map can hold
   localparam int MAX_PATTERN_DEF = 32;
   localparam int CHAR_W          = 8;
   localparam int LEN_W           = 6;
   localparam int CSR_DATA_W      = 64;
   localparam int CSR_ADDR_W      = 6;
   localparam int CSR_IDX_W       = 3;
   localparam int NUM_CHAR_REGS   = 4;

   localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
   localparam logic [CHAR_W-1:0] DOT_CHAR  = 8'h2E;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LEN    = 3'd0,
      REG_CHARS0 = 3'd1,
      REG_CHARS1 = 3'd2,
      REG_CHARS2 = 3'd3,
      REG_CHARS3 = 3'd4
   } csr_reg_type;

   // status of the match stage, seen by the top level
   typedef struct packed {
      logic in_full;
      logic in_last;
      logic fire;
   } nfa_stat_type;

   // Star closure as a parallel prefix: position j+1 becomes reachable from j
   // when prop_vec[j] (a '*' inside the pattern) is set.
   function automatic logic [PAT_LIMIT:0] swnm_closure(
      input logic [PAT_LIMIT:0]   set_vec,
      input logic [PAT_LIMIT-1:0] prop_vec
   );
      logic [PAT_LIMIT:0] g;
      logic [PAT_LIMIT:0] p;
      logic [PAT_LIMIT:0] g_nx;
      logic [PAT_LIMIT:0] p_nx;
      g = set_vec;
      p = {prop_vec, 1'b0};
      for (int d = 1; d <= PAT_LIMIT; d = d * 2) begin
         g_nx = g;
         p_nx = p;
         for (int j = d; j <= PAT_LIMIT; j++) begin
            g_nx[j] = g[j] | (p[j] & g[j-d]);
            p_nx[j] = p[j] & p[j-d];
         end
         g = g_nx;
         p = p_nx;
      end
      return g;
   endfunction

endpackage

`default_nettype wire

// ----- design/swnm_csr.sv -----
// ----------------------------------------------------------------------------
// swnm_csr: pattern registers
// APB-style register file plus the per-position masks derived from it.
// ----------------------------------------------------------------------------
`default_nettype none

module swnm_csr
   import swnm_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [CSR_ADDR_W-1:0]         paddr,
   input  wire logic [CSR_DATA_W-1:0]         pwdata,
   output logic      [CSR_DATA_W-1:0]         prdata,
   output logic                               pready,
   output logic      [CHAR_W*MAX_PATTERN-1:0] cfg_chars,
   output logic      [MAX_PATTERN-1:0]        cfg_star,
   output logic      [MAX_PATTERN-1:0]        cfg_act,
   output logic      [MAX_PATTERN:0]          cfg_init,
   output logic      [MAX_PATTERN:0]          cfg_final
);

   logic [LEN_W-1:0]      len_ff;
   logic [CSR_DATA_W-1:0] chars_ff [NUM_CHAR_REGS];

   logic [MAX_PATTERN-1:0] star_ff, star_in;
   logic [MAX_PATTERN-1:0] act_ff, act_in;
   logic [MAX_PATTERN:0]   init_ff, init_in;
   logic [MAX_PATTERN:0]   final_ff, final_in;

   logic [NUM_CHAR_REGS*CSR_DATA_W-1:0] chars_all;
   logic [LEN_W-1:0]                    eff_len;
   logic                                wr_en;
   csr_reg_type                         reg_idx;
   logic [PAT_LIMIT-1:0]                prop_ext;
   logic [PAT_LIMIT:0]                  seed_ext;
   logic [PAT_LIMIT:0]                  init_ext;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = csr_reg_type'(paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         for (int r = 0; r < NUM_CHAR_REGS; r++) begin
            chars_ff[r] <= '0;
         end
      end else if (wr_en) begin
         case (reg_idx)
            REG_LEN:    len_ff      <= pwdata[LEN_W-1:0];
            REG_CHARS0: chars_ff[0] <= pwdata;
            REG_CHARS1: chars_ff[1] <= pwdata;
            REG_CHARS2: chars_ff[2] <= pwdata;
            REG_CHARS3: chars_ff[3] <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_LEN:    prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, len_ff};
         REG_CHARS0: prdata = chars_ff[0];
         REG_CHARS1: prdata = chars_ff[1];
         REG_CHARS2: prdata = chars_ff[2];
         REG_CHARS3: prdata = chars_ff[3];
         default:    prdata = '0;
      endcase
   end

   assign chars_all = {chars_ff[3], chars_ff[2], chars_ff[1], chars_ff[0]};
   assign cfg_chars = chars_all[CHAR_W*MAX_PATTERN-1:0];

   // lengths past the pattern capacity clamp to it
   assign eff_len = (len_ff > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_ff;

   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         act_in[i]  = LEN_W'(i) < eff_len;
         star_in[i] = act_in[i] && (chars_all[CHAR_W*i +: CHAR_W] == STAR_CHAR);
      end
      for (int j = 0; j <= MAX_PATTERN; j++) begin
         final_in[j] = (eff_len == LEN_W'(j)) && (eff_len != '0);
      end
      prop_ext                = '0;
      prop_ext[MAX_PATTERN-1:0] = star_in;
      seed_ext                = '0;
      seed_ext[0]             = 1'b1;
      init_ext                = swnm_closure(seed_ext, prop_ext);
      init_in                 = init_ext[MAX_PATTERN:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         star_ff  <= '0;
         act_ff   <= '0;
         init_ff  <= '0;
         final_ff <= '0;
      end else begin
         star_ff  <= star_in;
         act_ff   <= act_in;
         init_ff  <= init_in;
         final_ff <= final_in;
      end
   end

   assign cfg_star  = star_ff;
   assign cfg_act   = act_ff;
   assign cfg_init  = init_ff;
   assign cfg_final = final_ff;

endmodule

`default_nettype wire

// ----- design/swnm_core.sv -----
// ----------------------------------------------------------------------------
// swnm_core: NFA match stage
// Input word register, reachable-position state, its combinational update with star
// closure, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swnm_core
   import swnm_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [CHAR_W-1:0]             req_name_char,
   input  wire logic                          req_last_char,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_matched,
   input  wire logic [CHAR_W*MAX_PATTERN-1:0] cfg_chars,
   input  wire logic [MAX_PATTERN-1:0]        cfg_star,
   input  wire logic [MAX_PATTERN-1:0]        cfg_act,
   input  wire logic [MAX_PATTERN:0]          cfg_init,
   input  wire logic [MAX_PATTERN:0]          cfg_final,
   output nfa_stat_type                       stat
);

   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_last_ff;

   logic [MAX_PATTERN:0] active_ff, active_in;
   logic                 start_ff, start_in;
   logic                 hidden_ff, hidden_in;

   logic out_valid_ff, out_valid_in;
   logic out_matched_ff;

   logic                 accept;
   logic                 fire;
   logic [MAX_PATTERN:0] cur;
   logic [PAT_LIMIT:0]   step_ext;
   logic [PAT_LIMIT-1:0] prop_ext;
   logic [PAT_LIMIT:0]   clos_ext;
   logic [MAX_PATTERN:0] nxt;
   logic                 hidden_now;
   logic                 match_now;

   // a word ending a name needs a free result slot
   assign fire      = in_valid_ff && (!in_last_ff || !out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cur        = start_ff ? cfg_init : active_ff;
      hidden_now = start_ff ? (in_char_ff == DOT_CHAR) : hidden_ff;
      step_ext   = '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (cur[i] && cfg_star[i]) begin
            step_ext[i] = 1'b1;
         end
         if (cur[i] && cfg_act[i] && !cfg_star[i]
             && (cfg_chars[CHAR_W*i +: CHAR_W] == in_char_ff)) begin
            step_ext[i+1] = 1'b1;
         end
      end
      prop_ext                  = '0;
      prop_ext[MAX_PATTERN-1:0] = cfg_star;
      clos_ext                  = swnm_closure(step_ext, prop_ext);
      nxt                       = clos_ext[MAX_PATTERN:0];
      match_now                 = !hidden_now && ((nxt & cfg_final) != '0);
   end

   always_comb begin
      active_in = active_ff;
      start_in  = start_ff;
      hidden_in = hidden_ff;
      if (fire) begin
         if (in_last_ff) begin
            active_in = '0;
            start_in  = 1'b1;
            hidden_in = 1'b0;
         end else begin
            active_in = nxt;
            start_in  = 1'b0;
            hidden_in = hidden_now;
         end
      end
   end

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (fire && in_last_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_stall) begin
         out_valid_in = out_valid_ff;
      end else begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         active_ff    <= '0;
         start_ff     <= 1'b1;
         hidden_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         active_ff    <= active_in;
         start_ff     <= start_in;
         hidden_ff    <= hidden_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_name_char;
         in_last_ff <= req_last_char;
      end
      if (fire && in_last_ff) begin
         out_matched_ff <= match_now;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_matched  = out_matched_ff;
   assign stat.in_full = in_valid_ff;
   assign stat.in_last = in_last_ff;
   assign stat.fire    = fire;

endmodule

`default_nettype wire

// ----- design/star_wildcard_name_match.sv -----
// ----------------------------------------------------------------------------
// star_wildcard_name_match: glob matcher for '*'-only patterns
// Streams file-name bytes and reports whether each whole name matches the
// pattern held in the registers.
// ----------------------------------------------------------------------------
// Usage:
//  - Load pattern_length (addr 0x00) and the pattern bytes (0x08..0x20, byte 0
//    in the low byte) over the APB port while no name is in flight. New
//    settings apply to words accepted from the cycle after the write.
//  - Send a name one byte per req word; req_last_char marks its final byte.
//    Only the final byte produces an rsp word, with rsp_matched set when the
//    whole name matches and does not start with '.'.
//  - One word per cycle sustained while no held result blocks a final byte.
//    A name's result shows on rsp_valid once its last byte has passed the
//    input register and then the result register; the position vector and
//    its star closure are updated combinationally between them.
//  - If rsp_stall holds a result, bytes that do not end a name keep flowing;
//    a final byte waits in the input register until the result slot frees.
//  - Reset clears the registers to zero (empty pattern matches nothing),
//    empties both stages and arms the start-of-name state.
// ----------------------------------------------------------------------------
`default_nettype none

module star_wildcard_name_match
   import swnm_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [CHAR_W-1:0]     req_name_char,
   input  wire logic                  req_last_char,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_matched,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   logic [CHAR_W*MAX_PATTERN-1:0] cfg_chars;
   logic [MAX_PATTERN-1:0]        cfg_star;
   logic [MAX_PATTERN-1:0]        cfg_act;
   logic [MAX_PATTERN:0]          cfg_init;
   logic [MAX_PATTERN:0]          cfg_final;
   nfa_stat_type                  stat;

   swnm_csr #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .cfg_chars (cfg_chars),
      .cfg_star  (cfg_star),
      .cfg_act   (cfg_act),
      .cfg_init  (cfg_init),
      .cfg_final (cfg_final)
   );

   swnm_core #(
      .MAX_PATTERN(MAX_PATTERN)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_name_char (req_name_char),
      .req_last_char (req_last_char),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_matched   (rsp_matched),
      .cfg_chars     (cfg_chars),
      .cfg_star      (cfg_star),
      .cfg_act       (cfg_act),
      .cfg_init      (cfg_init),
      .cfg_final     (cfg_final),
      .stat          (stat)
   );

   // stall only ever comes from a held word
   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> stat.in_full)
      else $error("req_stall without a held word");

   // a processed final byte always yields a result next cycle
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (stat.fire && stat.in_last) |=> rsp_valid)
      else $error("final byte processed but no result word");

   // a taken result is not shown again unless a new one was produced
   a_no_dup_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !(stat.fire && stat.in_last)) |=> !rsp_valid)
      else $error("result word repeated");

endmodule

`default_nettype wire
